/* hdl/fst_pkg.sv */
// Shared constants, codes and types of the Fibonacci search table.
package fst_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_W = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int FIB_W = CNT_W + 1;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_PROBE,
        S_COMPARE,
        S_FINAL_RD,
        S_FINAL_CMP,
        S_DONE
    } fst_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } fst_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [POS_W-1:0] position;
    } fst_res_t;

endpackage

/* hdl/fst_search.sv */
// Fibonacci search sequencer: grows the numbers, probes the table, narrows the range.
module fst_search (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fst_pkg::fst_req_t        req,
    input  logic                     ack,
    input  logic [fst_pkg::KEY_W-1:0] rd_data,
    output logic [fst_pkg::IDX_W-1:0] rd_addr,
    output fst_pkg::fst_res_t        res
);

    fst_pkg::fst_state_t            state_reg, state_next;
    logic [fst_pkg::FIB_W-1:0]      f_reg, f_next;
    logic [fst_pkg::FIB_W-1:0]      f1_reg, f1_next;
    logic [fst_pkg::FIB_W-1:0]      f2_reg, f2_next;
    logic [fst_pkg::CNT_W-1:0]      base_reg, base_next;   // offset plus one
    logic [fst_pkg::CNT_W-1:0]      probe_reg, probe_next;
    logic                           found_reg, found_next;
    logic [fst_pkg::POS_W-1:0]      pos_reg, pos_next;

    logic [fst_pkg::FIB_W-1:0]      n_ext;
    logic [fst_pkg::FIB_W:0]        sum;
    logic [fst_pkg::CNT_W-1:0]      probe;
    logic [fst_pkg::FIB_W-1:0]      diff;
    logic                           key_lt;
    logic                           key_eq;

    assign n_ext = fst_pkg::FIB_W'(req.count);
    assign sum = (fst_pkg::FIB_W + 1)'(base_reg) + (fst_pkg::FIB_W + 1)'(f2_reg);
    assign diff = f1_reg - f2_reg;
    assign key_lt = $signed(rd_data) < req.key;
    assign key_eq = rd_data == req.key;

    // clamp the probe to [0, count-1]
    always_comb begin
        if (sum == '0) begin
            probe = '0;
        end else if (sum > (fst_pkg::FIB_W + 1)'(req.count)) begin
            probe = req.count - 1'b1;
        end else begin
            probe = fst_pkg::CNT_W'(sum - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fst_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        f_reg     <= f_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        base_reg  <= base_next;
        probe_reg <= probe_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    always_comb begin
        state_next = state_reg;
        f_next     = f_reg;
        f1_next    = f1_reg;
        f2_next    = f2_reg;
        base_next  = base_reg;
        probe_next = probe_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        rd_addr    = fst_pkg::IDX_W'(probe);
        case (state_reg)
            fst_pkg::S_IDLE: begin
                if (req.start) begin
                    f2_next    = '0;
                    f1_next    = fst_pkg::FIB_W'(1);
                    f_next     = fst_pkg::FIB_W'(1);
                    base_next  = '0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = (req.count == '0) ? fst_pkg::S_DONE : fst_pkg::S_GROW;
                end
            end
            fst_pkg::S_GROW: begin
                if (f_reg < n_ext) begin
                    f2_next = f1_reg;
                    f1_next = f_reg;
                    f_next  = f1_reg + f_reg;
                end else begin
                    state_next = (f_reg > fst_pkg::FIB_W'(1)) ? fst_pkg::S_PROBE
                                                              : fst_pkg::S_FINAL_RD;
                end
            end
            fst_pkg::S_PROBE: begin
                // present the probe address; data returns next cycle
                probe_next = probe;
                state_next = fst_pkg::S_COMPARE;
            end
            fst_pkg::S_COMPARE: begin
                if (key_eq) begin
                    found_next = 1'b1;
                    pos_next   = fst_pkg::POS_W'(probe_reg);
                    state_next = fst_pkg::S_DONE;
                end else if (key_lt) begin
                    f_next     = f1_reg;
                    f1_next    = f2_reg;
                    f2_next    = diff;
                    base_next  = probe_reg + 1'b1;
                    state_next = (f1_reg > fst_pkg::FIB_W'(1)) ? fst_pkg::S_PROBE
                                                               : fst_pkg::S_FINAL_RD;
                end else begin
                    f_next     = f2_reg;
                    f1_next    = diff;
                    f2_next    = f2_reg - diff;
                    state_next = (f2_reg > fst_pkg::FIB_W'(1)) ? fst_pkg::S_PROBE
                                                               : fst_pkg::S_FINAL_RD;
                end
            end
            fst_pkg::S_FINAL_RD: begin
                rd_addr = fst_pkg::IDX_W'(base_reg);
                if (f1_reg != '0 && base_reg < req.count) begin
                    state_next = fst_pkg::S_FINAL_CMP;
                end else begin
                    state_next = fst_pkg::S_DONE;
                end
            end
            fst_pkg::S_FINAL_CMP: begin
                if (key_eq) begin
                    found_next = 1'b1;
                    pos_next   = fst_pkg::POS_W'(base_reg);
                end
                state_next = fst_pkg::S_DONE;
            end
            fst_pkg::S_DONE: begin
                if (ack) begin
                    state_next = fst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fst_pkg::S_IDLE;
            end
        endcase
    end

    assign res.done     = state_reg == fst_pkg::S_DONE;
    assign res.found    = found_reg;
    assign res.position = pos_reg;

endmodule

/* hdl/fibonacci_search_table.sv */
// Top level of the Fibonacci search table: key store, command decode, result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready  | s_command [1:0], s_key [31:0] signed
//  m_      | out | m_valid / m_ready  | m_status [2:0], m_position [6:0]
//
// Append, clear and unused commands finish in the accept cycle, result valid next cycle.
// A search runs under a small sequencer: the accept, the growth of the Fibonacci numbers,
// an exit step, then per probe an address, a registered read and a compare, then the
// final check and a done state that holds until the output register is free.
// s_ready is low while a search runs and while a result waits on a stalled m_ready.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module fibonacci_search_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fst_pkg::CMD_W-1:0]      s_command,
    input  logic signed [fst_pkg::KEY_W-1:0] s_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fst_pkg::STATUS_W-1:0]   m_status,
    output logic [fst_pkg::POS_W-1:0]      m_position
);

    // key store; entries at or above the count may be read but are never compared
    logic [fst_pkg::KEY_W-1:0]        mem [fst_pkg::TABLE_DEPTH];
    logic [fst_pkg::KEY_W-1:0]        rd_data_reg;
    logic [fst_pkg::IDX_W-1:0]        rd_addr;

    logic [fst_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic signed [fst_pkg::KEY_W-1:0] key_reg, key_next;
    logic                             m_valid_reg, m_valid_next;
    logic [fst_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [fst_pkg::POS_W-1:0]        position_reg, position_next;

    logic                             accept;
    logic                             out_free;
    logic                             wr_en;
    logic                             full;
    fst_pkg::fst_req_t                srch_req;
    fst_pkg::fst_res_t                srch_res;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !busy_reg && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = cnt_reg == fst_pkg::CNT_W'(fst_pkg::TABLE_DEPTH);
    assign wr_en    = accept && s_command == fst_pkg::CMD_APPEND && !full;

    assign srch_req.start = accept && s_command == fst_pkg::CMD_SEARCH;
    assign srch_req.key   = key_reg;
    assign srch_req.count = cnt_reg;

    // Hold the registered read port; write appends at the current count.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[fst_pkg::IDX_W'(cnt_reg)] <= s_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    fst_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (srch_req),
        .ack     (out_free),
        .rd_data (rd_data_reg),
        .rd_addr (rd_addr),
        .res     (srch_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    always_comb begin
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        position_next = position_reg;
        if (accept) begin
            key_next      = s_key;
            m_valid_next  = 1'b1;
            position_next = '0;
            case (s_command)
                fst_pkg::CMD_APPEND: begin
                    if (full) begin
                        status_next = fst_pkg::ST_FULL;
                    end else begin
                        status_next   = fst_pkg::ST_STORED;
                        position_next = fst_pkg::POS_W'(cnt_reg);
                        cnt_next      = cnt_reg + 1'b1;
                    end
                end
                fst_pkg::CMD_SEARCH: begin
                    // result comes later from the sequencer
                    m_valid_next = 1'b0;
                    busy_next    = 1'b1;
                end
                fst_pkg::CMD_CLEAR: begin
                    status_next = fst_pkg::ST_CLEARED;
                    cnt_next    = '0;
                end
                default: begin
                    status_next = fst_pkg::ST_NOT_FOUND;
                end
            endcase
        end else if (busy_reg && srch_res.done && out_free) begin
            // take the search result into the output register
            busy_next     = 1'b0;
            m_valid_next  = 1'b1;
            status_next   = srch_res.found ? fst_pkg::ST_FOUND : fst_pkg::ST_NOT_FOUND;
            position_next = srch_res.found ? srch_res.position : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_position = position_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= fst_pkg::CNT_W'(fst_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_start_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_req.start |=> busy_reg && !m_valid_reg)
        else $error("search start did not mark the block busy");

    a_done_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_res.done |-> busy_reg)
        else $error("search done while no search is pending");

    a_found_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (srch_res.done && srch_res.found) |-> (fst_pkg::CNT_W'(srch_res.position) < cnt_reg
                                               || cnt_reg > fst_pkg::CNT_W'(127)))
        else $error("found position beyond stored entries");

    a_append_stores: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid_reg && status_reg == fst_pkg::ST_STORED
                  && cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("append did not store and count");

endmodule
